@@ rtl/core/tsts_pkg.sv @@
// Package with shared types and constants of the task state table scheduler.
`timescale 1ns / 1ps
package tsts_pkg;

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_CREATED  = 3'd1;
    localparam logic [2:0] ST_RUNNABLE = 3'd2;
    localparam logic [2:0] ST_RUNNING  = 3'd3;
    localparam logic [2:0] ST_WAITING  = 3'd4;
    localparam logic [2:0] ST_ZOMBIE   = 3'd5;

    localparam logic [11:0] SLEEP_TAG = 12'hFFF;

    localparam logic [2:0] R_OK       = 3'd0;
    localparam logic [2:0] R_FULL     = 3'd1;
    localparam logic [2:0] R_NORUN    = 3'd2;
    localparam logic [2:0] R_NONE     = 3'd3;
    localparam logic [2:0] R_BLOCKED  = 3'd4;
    localparam logic [2:0] R_BADSTATE = 3'd5;

    localparam logic [3:0] M_CREATE    = 4'd0;
    localparam logic [3:0] M_READY     = 4'd1;
    localparam logic [3:0] M_SCHEDULE  = 4'd2;
    localparam logic [3:0] M_YIELD     = 4'd3;
    localparam logic [3:0] M_SUSPEND   = 4'd4;
    localparam logic [3:0] M_SLEEP     = 4'd5;
    localparam logic [3:0] M_WAKEUP    = 4'd6;
    localparam logic [3:0] M_TICK      = 4'd7;
    localparam logic [3:0] M_TERMINATE = 4'd8;
    localparam logic [3:0] M_WAIT      = 4'd9;

    typedef struct packed {
        logic [3:0]         mode;
        logic [1:0]         cpu_index;
        logic [3:0]         target_slot;
        logic [11:0]        wait_tag;
        logic [31:0]        sleep_length;
        logic signed [31:0] exit_value;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         chosen_slot;
        logic [31:0]        task_id;
        logic signed [31:0] collected_exit;
        logic [4:0]         woken_count;
        logic [31:0]        tick_total;
    } t_rsp;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture the command
        logic exec;     // apply the command
        logic scan;     // one schedule scan step
    } t_ctl;

    // Datapath to controller.
    typedef struct packed {
        logic is_sched;   // command needs the scan loop
        logic scan_done;  // scan finished this step
    } t_sts;

endpackage

@@ rtl/core/tsts_ctrl.sv @@
// Controller state machine of the task state table scheduler.
`timescale 1ns / 1ps
module tsts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  tsts_pkg::t_sts i_sts,
    output tsts_pkg::t_ctl o_ctl
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_sched) begin
                    n_state = S_SCAN;
                end else begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

@@ rtl/core/tsts_dp.sv @@
// Datapath of the task state table scheduler: entry table, CPU state, result.
`timescale 1ns / 1ps
module tsts_dp #(
    parameter int SLOTS = 16,
    parameter int CPUS  = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tsts_pkg::t_cmd i_cmd,
    input  tsts_pkg::t_ctl i_ctl,
    output tsts_pkg::t_sts o_sts,
    output tsts_pkg::t_rsp o_rsp
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = (CPUS > 1) ? $clog2(CPUS) : 1;

    logic [2:0]  r_stat [SLOTS];
    logic [11:0] r_tag  [SLOTS];
    logic [31:0] r_slp  [SLOTS];
    logic [31:0] r_id   [SLOTS];
    logic [31:0] r_exit [SLOTS];
    logic [CPUS-1:0] r_cval;
    logic [SW-1:0]   r_crun [CPUS];
    logic [SW-1:0]   r_cptr [CPUS];
    logic [31:0] r_ticks, r_ids;
    tsts_pkg::t_cmd r_cmd;
    tsts_pkg::t_rsp r_rsp;
    logic [SW:0] r_k;     // scan step count within one lap

    logic [CW-1:0] cpu;
    logic          run, tgt_ok;
    logic [SW-1:0] cur, tgt, si, si_next;
    logic [11:0]   ttag;
    logic [4:0]    cidx;
    logic [SW+1:0] ssum;

    always_comb begin
        // The CPU index is below four, so three compare and subtract steps
        // reduce it modulo CPUS for every legal CPU count.
        cidx = 5'(r_cmd.cpu_index);
        for (int j = 0; j < 3; j++) begin
            if (cidx >= 5'(CPUS)) cidx = cidx - 5'(CPUS);
        end
        cpu    = CW'(cidx);
        run    = r_cval[cpu];
        cur    = r_crun[cpu];
        tgt_ok = (7'(r_cmd.target_slot) < 7'(SLOTS));
        tgt    = SW'(r_cmd.target_slot);
        // Pointer plus step stays below twice the table size, so one
        // subtraction wraps it around the table.
        ssum   = (SW+2)'(r_cptr[cpu]) + (SW+2)'(r_k);
        si     = (ssum >= (SW+2)'(SLOTS)) ? SW'(ssum - (SW+2)'(SLOTS)) : SW'(ssum);
        si_next = (si == SW'(SLOTS - 1)) ? '0 : si + SW'(1);
        ttag   = 12'(r_cmd.target_slot) + 12'd1;
    end

    assign o_sts.is_sched  = (r_cmd.mode == tsts_pkg::M_SCHEDULE) && !run;
    assign o_sts.scan_done = (r_k == (SW+1)'(SLOTS - 1))
                             || (r_stat[si] == tsts_pkg::ST_RUNNABLE);
    assign o_rsp = r_rsp;

    logic [SW-1:0] free_i;
    logic          free_f;
    always_comb begin
        free_f = 1'b0;
        free_i = '0;
        for (int i = SLOTS-1; i >= 0; i--) begin
            if (r_stat[i] == tsts_pkg::ST_UNUSED) begin
                free_f = 1'b1;
                free_i = SW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_stat[i] <= tsts_pkg::ST_UNUSED;
                r_tag[i]  <= '0;
            end
            r_cval  <= '0;
            for (int c = 0; c < CPUS; c++) begin
                r_crun[c] <= '0;
                r_cptr[c] <= '0;
            end
            r_ticks <= '0;
            r_ids   <= '0;
            r_k     <= '0;
        end else if (i_ctl.load) begin
            r_cmd <= i_cmd;
            r_k   <= '0;
            r_rsp <= '{tick_total: r_ticks, default: '0};
        end else if (i_ctl.scan) begin
            r_k <= r_k + 1'b1;
            if (r_stat[si] == tsts_pkg::ST_ZOMBIE) r_stat[si] <= tsts_pkg::ST_UNUSED;
            if (r_stat[si] == tsts_pkg::ST_RUNNABLE) begin
                r_stat[si]   <= tsts_pkg::ST_RUNNING;
                r_cval[cpu]  <= 1'b1;
                r_crun[cpu]  <= si;
                r_cptr[cpu]  <= si_next;
                r_rsp.chosen_slot <= 4'(si);
                r_rsp.task_id     <= r_id[si];
            end else if (r_k == (SW+1)'(SLOTS - 1)) begin
                r_rsp.status <= tsts_pkg::R_NONE;
            end
        end else if (i_ctl.exec) begin
            case (r_cmd.mode)
                tsts_pkg::M_CREATE: begin
                    if (free_f) begin
                        r_ids <= r_ids + 32'd1;
                        r_id[free_i]   <= r_ids + 32'd1;
                        r_tag[free_i]  <= '0;
                        r_stat[free_i] <= tsts_pkg::ST_CREATED;
                        r_rsp.chosen_slot <= 4'(free_i);
                        r_rsp.task_id     <= r_ids + 32'd1;
                    end else r_rsp.status <= tsts_pkg::R_FULL;
                end
                tsts_pkg::M_READY: begin
                    if (!tgt_ok || r_stat[tgt] != tsts_pkg::ST_CREATED)
                        r_rsp.status <= tsts_pkg::R_BADSTATE;
                    else begin
                        r_stat[tgt] <= tsts_pkg::ST_RUNNABLE;
                        r_rsp.chosen_slot <= r_cmd.target_slot;
                    end
                end
                tsts_pkg::M_SCHEDULE: r_rsp.status <= tsts_pkg::R_BADSTATE;
                tsts_pkg::M_YIELD, tsts_pkg::M_SUSPEND, tsts_pkg::M_SLEEP,
                tsts_pkg::M_TERMINATE: begin
                    if (!run) r_rsp.status <= tsts_pkg::R_NORUN;
                    else begin
                        logic [4:0] n;
                        n = '0;
                        r_rsp.chosen_slot <= 4'(cur);
                        r_cval[cpu] <= 1'b0;
                        if (r_cmd.mode == tsts_pkg::M_YIELD)
                            r_stat[cur] <= tsts_pkg::ST_RUNNABLE;
                        else if (r_cmd.mode == tsts_pkg::M_SUSPEND) begin
                            r_tag[cur]  <= r_cmd.wait_tag;
                            r_stat[cur] <= tsts_pkg::ST_WAITING;
                            r_rsp.status <= tsts_pkg::R_BLOCKED;
                        end else if (r_cmd.mode == tsts_pkg::M_SLEEP) begin
                            r_slp[cur]  <= r_cmd.sleep_length;
                            r_tag[cur]  <= tsts_pkg::SLEEP_TAG;
                            r_stat[cur] <= tsts_pkg::ST_WAITING;
                            r_rsp.status <= tsts_pkg::R_BLOCKED;
                        end else begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (SW'(i) != cur && r_stat[i] == tsts_pkg::ST_WAITING
                                    && r_tag[i] == 12'(cur) + 12'd1) begin
                                    r_stat[i] <= tsts_pkg::ST_RUNNABLE;
                                    r_tag[i]  <= '0;
                                    n = n + 5'd1;
                                end
                            end
                            r_stat[cur] <= tsts_pkg::ST_ZOMBIE;
                            r_exit[cur] <= r_cmd.exit_value;
                            r_tag[cur]  <= '0;
                            r_rsp.woken_count <= n;
                        end
                    end
                end
                tsts_pkg::M_WAKEUP: begin
                    logic [4:0] n;
                    n = '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!(run && SW'(i) == cur) && r_stat[i] == tsts_pkg::ST_WAITING
                            && r_tag[i] == r_cmd.wait_tag) begin
                            r_stat[i] <= tsts_pkg::ST_RUNNABLE;
                            r_tag[i]  <= '0;
                            n = n + 5'd1;
                        end
                    end
                    r_rsp.woken_count <= n;
                end
                tsts_pkg::M_TICK: begin
                    logic [4:0] n;
                    n = '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (r_stat[i] == tsts_pkg::ST_WAITING
                            && r_tag[i] == tsts_pkg::SLEEP_TAG) begin
                            r_slp[i] <= r_slp[i] - 32'd1;
                            if (r_slp[i] == 32'd1) begin
                                r_stat[i] <= tsts_pkg::ST_RUNNABLE;
                                r_tag[i]  <= '0;
                                n = n + 5'd1;
                            end
                        end
                    end
                    r_ticks <= r_ticks + 32'd1;
                    r_rsp.tick_total  <= r_ticks + 32'd1;
                    r_rsp.woken_count <= n;
                end
                tsts_pkg::M_WAIT: begin
                    if (!run) r_rsp.status <= tsts_pkg::R_NORUN;
                    else if (!tgt_ok || r_stat[tgt] == tsts_pkg::ST_UNUSED)
                        r_rsp.status <= tsts_pkg::R_BADSTATE;
                    else if (r_stat[tgt] == tsts_pkg::ST_ZOMBIE) begin
                        r_rsp.collected_exit <= r_exit[tgt];
                        r_stat[tgt] <= tsts_pkg::ST_UNUSED;
                        r_rsp.chosen_slot <= r_cmd.target_slot;
                    end else begin
                        r_tag[cur]  <= ttag;
                        r_stat[cur] <= tsts_pkg::ST_WAITING;
                        r_cval[cpu] <= 1'b0;
                        r_rsp.chosen_slot <= r_cmd.target_slot;
                        r_rsp.status <= tsts_pkg::R_BLOCKED;
                    end
                end
                default: r_rsp.status <= tsts_pkg::R_BADSTATE;
            endcase
        end
    end
endmodule

@@ rtl/core/task_state_table_scheduler_core.sv @@
// Top level of the task state table scheduler.
`timescale 1ns / 1ps
// One command transfer at a time: a command passes from its input transfer
// to its result being offered through capture, execute and present steps, and a
// schedule command for an idle CPU adds a round-robin scan step per entry visited,
// at most SLOTS entries, since the scan walks the table one entry per cycle. The
// next input transfer is taken the cycle after the result transfer.
module task_state_table_scheduler_core #(
    parameter int SLOTS = 16,
    parameter int CPUS  = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tsts_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_stall,
    output tsts_pkg::t_rsp o_rsp
);
    tsts_pkg::t_ctl ctl;
    tsts_pkg::t_sts sts;

    // The controller sequences each command; the datapath holds the table, CPU and result state.
    tsts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .i_sts(sts), .o_ctl(ctl)
    );

    tsts_dp #(.SLOTS(SLOTS), .CPUS(CPUS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(i_cmd), .i_ctl(ctl),
        .o_sts(sts), .o_rsp(o_rsp)
    );

`ifndef SYNTHESIS
    // An input transfer is never taken while a result is offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input taken while result pending");
    // Capture, execute and scan steps never coincide.
    a_ctl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(ctl)) else $error("conflicting control commands");
    // A capture is followed by no result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load |=> !o_valid) else $error("result too early");
`endif
endmodule

@@ verif/task_state_table_scheduler_core_test.sv @@
// Self-checking testbench for the task state table scheduler core.
`timescale 1ns / 1ps
module task_state_table_scheduler_core_test;

    localparam int SLOTS = 16;
    localparam int CPUS  = 4;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    tsts_pkg::t_cmd i_cmd;
    logic o_valid;
    logic i_stall;
    tsts_pkg::t_rsp o_rsp;

    task_state_table_scheduler_core #(.SLOTS(SLOTS), .CPUS(CPUS)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    // The clock runs with a 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Shadow copy of the task table, advanced once per accepted command transfer.
    logic [2:0]  tbl_status [SLOTS];
    logic [11:0] tbl_tag    [SLOTS];
    logic [31:0] tbl_sleep  [SLOTS];
    logic [31:0] tbl_id     [SLOTS];
    logic [31:0] tbl_exit   [SLOTS];
    logic [31:0] tbl_slept  [SLOTS];  // nonzero once the entry has really slept
    logic        cpu_busy   [CPUS];
    logic [3:0]  cpu_slot   [CPUS];
    logic [3:0]  cpu_ptr    [CPUS];
    logic [31:0] ticks;
    logic [31:0] ids;

    tsts_pkg::t_cmd pending_cmds[$];
    tsts_pkg::t_rsp expected_rsps[$];
    int   mismatches;
    logic quiet;   // no idling on either side near the end of the run

    // Wakes every waiter on a tag, optionally sparing one slot, and counts them.
    function automatic logic [4:0] wake_waiters(logic [11:0] tag, logic spare,
                                                logic [3:0] spared);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!(spare && i == spared) && tbl_status[i] == tsts_pkg::ST_WAITING
                && tbl_tag[i] == tag) begin
                tbl_status[i] = tsts_pkg::ST_RUNNABLE;
                tbl_tag[i] = '0;
                n++;
            end
        end
        return n;
    endfunction

    // Applies one command to the shadow table and returns the result it must give.
    function automatic tsts_pkg::t_rsp apply_command(tsts_pkg::t_cmd c);
        tsts_pkg::t_rsp r;
        logic [1:0] cpu;
        logic [3:0] cur;
        logic [3:0] p;
        logic [3:0] i;
        logic found;
        r = '0;
        cpu = c.cpu_index;
        cur = cpu_slot[cpu];
        case (c.mode)
            tsts_pkg::M_CREATE: begin
                found = 1'b0;
                for (int k = 0; k < SLOTS && !found; k++) begin
                    if (tbl_status[k] == tsts_pkg::ST_UNUSED) begin
                        found = 1'b1;
                        ids++;
                        tbl_id[k] = ids;
                        tbl_tag[k] = '0;
                        tbl_status[k] = tsts_pkg::ST_CREATED;
                        r.chosen_slot = k[3:0];
                        r.task_id = ids;
                    end
                end
                if (!found) r.status = tsts_pkg::R_FULL;
            end
            tsts_pkg::M_READY: begin
                if (tbl_status[c.target_slot] != tsts_pkg::ST_CREATED) begin
                    r.status = tsts_pkg::R_BADSTATE;
                end else begin
                    tbl_status[c.target_slot] = tsts_pkg::ST_RUNNABLE;
                    r.chosen_slot = c.target_slot;
                end
            end
            tsts_pkg::M_SCHEDULE: begin
                if (cpu_busy[cpu]) begin
                    r.status = tsts_pkg::R_BADSTATE;
                end else begin
                    found = 1'b0;
                    p = cpu_ptr[cpu];
                    for (int k = 0; k < SLOTS && !found; k++) begin
                        i = p + k[3:0];
                        if (tbl_status[i] == tsts_pkg::ST_ZOMBIE) begin
                            tbl_status[i] = tsts_pkg::ST_UNUSED;
                        end else if (tbl_status[i] == tsts_pkg::ST_RUNNABLE) begin
                            found = 1'b1;
                            tbl_status[i] = tsts_pkg::ST_RUNNING;
                            cpu_busy[cpu] = 1'b1;
                            cpu_slot[cpu] = i;
                            cpu_ptr[cpu] = i + 4'd1;
                            r.chosen_slot = i;
                            r.task_id = tbl_id[i];
                        end
                    end
                    if (!found) r.status = tsts_pkg::R_NONE;
                end
            end
            tsts_pkg::M_YIELD, tsts_pkg::M_SUSPEND, tsts_pkg::M_SLEEP,
            tsts_pkg::M_TERMINATE: begin
                if (!cpu_busy[cpu]) begin
                    r.status = tsts_pkg::R_NORUN;
                end else begin
                    r.chosen_slot = cur;
                    cpu_busy[cpu] = 1'b0;
                    if (c.mode == tsts_pkg::M_YIELD) begin
                        tbl_status[cur] = tsts_pkg::ST_RUNNABLE;
                    end else if (c.mode == tsts_pkg::M_SUSPEND) begin
                        tbl_tag[cur] = c.wait_tag;
                        tbl_status[cur] = tsts_pkg::ST_WAITING;
                        r.status = tsts_pkg::R_BLOCKED;
                    end else if (c.mode == tsts_pkg::M_SLEEP) begin
                        tbl_sleep[cur] = c.sleep_length;
                        tbl_slept[cur] = 1;
                        tbl_tag[cur] = tsts_pkg::SLEEP_TAG;
                        tbl_status[cur] = tsts_pkg::ST_WAITING;
                        r.status = tsts_pkg::R_BLOCKED;
                    end else begin
                        tbl_status[cur] = tsts_pkg::ST_ZOMBIE;
                        tbl_exit[cur] = c.exit_value;
                        tbl_tag[cur] = '0;
                        r.woken_count = wake_waiters({8'd0, cur} + 12'd1, 1'b1, cur);
                    end
                end
            end
            tsts_pkg::M_WAKEUP: r.woken_count = wake_waiters(c.wait_tag, cpu_busy[cpu], cur);
            tsts_pkg::M_TICK: begin
                ticks++;
                for (int k = 0; k < SLOTS; k++) begin
                    if (tbl_status[k] == tsts_pkg::ST_WAITING
                        && tbl_tag[k] == tsts_pkg::SLEEP_TAG) begin
                        tbl_sleep[k]--;
                        if (tbl_sleep[k] == 0) begin
                            tbl_status[k] = tsts_pkg::ST_RUNNABLE;
                            tbl_tag[k] = '0;
                            r.woken_count++;
                        end
                    end
                end
            end
            tsts_pkg::M_WAIT: begin
                if (!cpu_busy[cpu]) begin
                    r.status = tsts_pkg::R_NORUN;
                end else if (tbl_status[c.target_slot] == tsts_pkg::ST_UNUSED) begin
                    r.status = tsts_pkg::R_BADSTATE;
                end else if (tbl_status[c.target_slot] == tsts_pkg::ST_ZOMBIE) begin
                    r.collected_exit = tbl_exit[c.target_slot];
                    tbl_status[c.target_slot] = tsts_pkg::ST_UNUSED;
                    r.chosen_slot = c.target_slot;
                end else begin
                    tbl_tag[cur] = {8'd0, c.target_slot} + 12'd1;
                    tbl_status[cur] = tsts_pkg::ST_WAITING;
                    cpu_busy[cpu] = 1'b0;
                    r.chosen_slot = c.target_slot;
                    r.status = tsts_pkg::R_BLOCKED;
                end
            end
            default: r.status = tsts_pkg::R_BADSTATE;
        endcase
        r.tick_total = ticks;
        return r;
    endfunction

    // A suspend may not use the sleep tag unless the caller has a countdown on
    // record, since a later tick would then read a countdown that was never
    // written.
    function automatic tsts_pkg::t_cmd make_safe(tsts_pkg::t_cmd c);
        if (c.mode == tsts_pkg::M_SUSPEND && c.wait_tag == tsts_pkg::SLEEP_TAG
            && cpu_busy[c.cpu_index] && tbl_slept[cpu_slot[c.cpu_index]] == 0) begin
            c.wait_tag = 12'hFFE;
        end
        return c;
    endfunction

    // Random command, weighted toward sequences that reach running tasks.
    function automatic tsts_pkg::t_cmd random_command();
        tsts_pkg::t_cmd c;
        int pick;
        c.cpu_index = 2'($urandom_range(0, 3));
        c.target_slot = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 5) c.wait_tag = tsts_pkg::SLEEP_TAG;
        else if (pick < 50) c.wait_tag = 12'($urandom_range(1, 16));
        else c.wait_tag = 12'($urandom_range(0, 4095));
        pick = $urandom_range(0, 9);
        if (pick < 8) c.sleep_length = $urandom_range(1, 4);
        else if (pick == 8) c.sleep_length = $urandom;
        else c.sleep_length = 0;
        c.exit_value = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 12) c.mode = tsts_pkg::M_CREATE;
        else if (pick < 24) c.mode = tsts_pkg::M_READY;
        else if (pick < 42) c.mode = tsts_pkg::M_SCHEDULE;
        else if (pick < 48) c.mode = tsts_pkg::M_YIELD;
        else if (pick < 53) c.mode = tsts_pkg::M_SUSPEND;
        else if (pick < 58) c.mode = tsts_pkg::M_SLEEP;
        else if (pick < 64) c.mode = tsts_pkg::M_WAKEUP;
        else if (pick < 76) c.mode = tsts_pkg::M_TICK;
        else if (pick < 86) c.mode = tsts_pkg::M_TERMINATE;
        else if (pick < 97) c.mode = tsts_pkg::M_WAIT;
        else c.mode = 4'($urandom_range(10, 15));
        return c;
    endfunction

    function automatic tsts_pkg::t_cmd build_cmd(logic [3:0] m, logic [1:0] cpu,
                                                 logic [3:0] slot, logic [11:0] tag,
                                                 logic [31:0] len, logic [31:0] xv);
        tsts_pkg::t_cmd c;
        c.mode = m;
        c.cpu_index = cpu;
        c.target_slot = slot;
        c.wait_tag = tag;
        c.sleep_length = len;
        c.exit_value = xv;
        return c;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    // Driver: offers the oldest pending command, idling in random bursts.
    // The payload and valid only change once the current transfer has happened.
    int send_gap;
    logic hold_sender;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) void'(pending_cmds.pop_front());
            if (send_gap > 0) send_gap--;
            else if (!quiet && $urandom_range(0, 15) == 0) send_gap = $urandom_range(1, 14);
            if (send_gap == 0 && !hold_sender && pending_cmds.size() > 0) begin
                // Sanitize and predict at the moment the command is committed.
                pending_cmds[0] = make_safe(pending_cmds[0]);
                expected_rsps.push_back(apply_command(pending_cmds[0]));
                i_cmd <= pending_cmds[0];
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation.
    int stall_left;
    always @(posedge i_clk) begin
        tsts_pkg::t_rsp want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, 32'd0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_rsp.status !== want.status)
                        report_mismatch("status", 32'(o_rsp.status), 32'(want.status));
                    if (o_rsp.chosen_slot !== want.chosen_slot)
                        report_mismatch("chosen_slot", 32'(o_rsp.chosen_slot),
                                        32'(want.chosen_slot));
                    if (o_rsp.task_id !== want.task_id)
                        report_mismatch("task_id", o_rsp.task_id, want.task_id);
                    if (o_rsp.collected_exit !== want.collected_exit)
                        report_mismatch("collected_exit", o_rsp.collected_exit,
                                        want.collected_exit);
                    if (o_rsp.woken_count !== want.woken_count)
                        report_mismatch("woken_count", 32'(o_rsp.woken_count),
                                        32'(want.woken_count));
                    if (o_rsp.tick_total !== want.tick_total)
                        report_mismatch("tick_total", o_rsp.tick_total, want.tick_total);
                end
            end
            if (stall_left > 0) stall_left--;
            else if (!quiet && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 14);
            i_stall <= (stall_left > 0);
        end
    end

    // Stimulus and end of run. Prediction happens in the driver, so the state
    // used for sanitizing always matches the command order.
    initial begin
        for (int k = 0; k < SLOTS; k++) begin
            tbl_status[k] = tsts_pkg::ST_UNUSED;
            tbl_tag[k] = '0;
            tbl_sleep[k] = '0;
            tbl_id[k] = '0;
            tbl_exit[k] = '0;
            tbl_slept[k] = '0;
        end
        for (int k = 0; k < CPUS; k++) begin
            cpu_busy[k] = 1'b0;
            cpu_slot[k] = '0;
            cpu_ptr[k] = '0;
        end
        ticks = '0;
        ids = '0;
        mismatches = 0;
        quiet = 1'b0;
        hold_sender = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cmd = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: idle-CPU errors, an empty scan, a full lifecycle,
        // sleep of zero and of max, wakeups, a zombie collected by wait,
        // a full table and unknown modes.
        pending_cmds.push_back(build_cmd(tsts_pkg::M_YIELD, 0, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_WAIT, 1, 15, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_SCHEDULE, 3, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_CREATE, 0, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_READY, 0, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_READY, 0, 15, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_SCHEDULE, 0, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_SCHEDULE, 0, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_WAKEUP, 0, 0, 4094, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_SLEEP, 0, 0, 1, 32'hFFFF_FFFF, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_TICK, 0, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_WAKEUP, 2, 0, tsts_pkg::SLEEP_TAG, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_SCHEDULE, 1, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_SLEEP, 1, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_WAKEUP, 2, 0, tsts_pkg::SLEEP_TAG, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_SCHEDULE, 2, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_WAIT, 2, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_CREATE, 3, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_READY, 3, 1, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_SCHEDULE, 3, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_TERMINATE, 3, 0, 1, 0, 32'h8000_0000));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_YIELD, 2, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_SCHEDULE, 2, 0, 1, 0, 0));
        pending_cmds.push_back(build_cmd(tsts_pkg::M_WAIT, 2, 1, 1, 0, 0));
        pending_cmds.push_back(build_cmd(4'd15, 0, 0, 1, 0, 32'h7FFF_FFFF));
        for (int k = 0; k < 17; k++)
            pending_cmds.push_back(build_cmd(tsts_pkg::M_CREATE, 0, 0, 1, 0, 0));

        // Random part, with one pause until every expected result is back.
        for (int k = 0; k < 1900; k++) begin
            if (k == 900) begin
                wait (pending_cmds.size() == 0);
                hold_sender = 1'b1;
                wait (expected_rsps.size() == 0 && !i_valid);
                hold_sender = 1'b0;
            end
            if (k == 1700) quiet = 1'b1;
            pending_cmds.push_back(random_command());
            while (pending_cmds.size() > 8) @(posedge i_clk);
        end
        wait (pending_cmds.size() == 0);
        wait (expected_rsps.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

@@ task_state_table_scheduler_core.f @@
rtl/core/tsts_pkg.sv
rtl/core/tsts_ctrl.sv
rtl/core/tsts_dp.sv
rtl/core/task_state_table_scheduler_core.sv
verif/task_state_table_scheduler_core_test.sv
